// ===== design/dsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and constants of the distinct subsequence counter: payload
// structs, command codes, controller states and controller/datapath buses.
// ----------------------------------------------------------------------------
package dsc_pkg;

   // Default depth of the pattern store
   localparam int DEF_MAX_PATTERN = 64;

   localparam int SYMBOL_W = 8;
   localparam int COUNT_W  = 32;

   // Input transaction command codes (code 3 is unused and ignored)
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_SOURCE = 2'd2
   } dsc_cmd_type;

   typedef struct packed {
      logic [1:0]          command;
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
   } dsc_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               pattern_truncated;
   } dsc_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_FINAL,
      ST_EMIT
   } dsc_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clear;       // empty pattern, drop flag, restart row
      logic append;      // store a pattern symbol, restart row
      logic start;       // latch source symbol, load position counter
      logic update;      // add, write back, step position down
      logic read_final;  // point read port A at the full-pattern entry
      logic load_rsp;    // capture result, restart row
   } dsc_ctl_type;

   // Datapath to controller status
   typedef struct packed {
      logic len_zero;
      logic idx_one;
   } dsc_sts_type;

endpackage

// ===== design/dsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsc_ctrl
// Sequencer: decodes input transactions, walks the pattern positions and
// owns both handshakes.
// ----------------------------------------------------------------------------
module dsc_ctrl
   import dsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dsc_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dsc_ctl_type ctl,
   input  dsc_sts_type sts
);

   dsc_state_type state_ff, state_in;
   logic          last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_fire;

   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      ctl          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               if (req_payload.command == CMD_CLEAR) begin
                  ctl.clear = 1'b1;
               end else if (req_payload.command == CMD_APPEND) begin
                  ctl.append = 1'b1;
               end else if (req_payload.command == CMD_SOURCE) begin
                  ctl.start = 1'b1;
                  last_in   = req_payload.last;
                  if (!sts.len_zero) begin
                     state_in = ST_READ;
                  end else if (req_payload.last) begin
                     state_in = ST_FINAL;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            ctl.update = 1'b1;
            if (sts.idx_one) begin
               state_in = last_ff ? ST_FINAL : ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_FINAL: begin
            ctl.read_final = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            // keep the full-pattern entry on read port A while waiting
            ctl.read_final = 1'b1;
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result appeared outside the emit step");

   a_last_source_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.command == CMD_SOURCE && req_payload.last)
      |=> state_ff != ST_IDLE)
      else $error("final source transaction did not start a result");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("free output register was not loaded");
`endif

endmodule

// ===== design/dsc_datapath.sv =====
// ----------------------------------------------------------------------------
// dsc_datapath
// Pattern store, count row memory with per-entry valid bits, position
// counter, compare and add, and the result register.
// ----------------------------------------------------------------------------
module dsc_datapath
   import dsc_pkg::*;
#(
   parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
   input  logic        clock,
   input  logic        reset,
   input  dsc_req_type req_payload,
   input  dsc_ctl_type ctl,
   output dsc_sts_type sts,
   output dsc_rsp_type rsp_payload
);

   localparam int CW = $clog2(MAX_PATTERN + 1);
   localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [SYMBOL_W-1:0] pat_mem [MAX_PATTERN];
   logic [COUNT_W-1:0]  cnt_mem [MAX_PATTERN + 1];
   logic [MAX_PATTERN:0] valid_ff;

   logic [CW-1:0]       plen_ff;
   logic                trunc_ff;
   logic [CW-1:0]       idx_ff;
   logic [SYMBOL_W-1:0] sym_ff;

   logic [SYMBOL_W-1:0] pat_rd_ff;
   logic [COUNT_W-1:0]  a_data_ff, b_data_ff;
   logic                a_valid_ff, b_valid_ff;
   logic                a_zero_ff, b_zero_ff;
   dsc_rsp_type         rsp_ff;

   logic [CW-1:0]       addr_a, addr_b;
   logic [PW-1:0]       pat_addr;
   logic [COUNT_W-1:0]  a_val, b_val, sum;
   logic                room, match, restart;

   assign room     = plen_ff < CW'(MAX_PATTERN);
   assign addr_a   = ctl.read_final ? plen_ff : idx_ff;
   assign addr_b   = idx_ff - CW'(1);
   assign pat_addr = addr_b[PW-1:0];
   assign restart  = ctl.clear || ctl.append || ctl.load_rsp;

   // entry zero is always one; entries never written since restart are zero
   assign a_val = a_zero_ff ? COUNT_W'(1) : (a_valid_ff ? a_data_ff : '0);
   assign b_val = b_zero_ff ? COUNT_W'(1) : (b_valid_ff ? b_data_ff : '0);
   assign sum   = a_val + b_val;
   assign match = pat_rd_ff == sym_ff;

   assign sts.len_zero = plen_ff == '0;
   assign sts.idx_one  = idx_ff == CW'(1);
   assign rsp_payload  = rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff  <= '0;
         trunc_ff <= 1'b0;
         valid_ff <= '0;
         idx_ff   <= '0;
      end else begin
         if (ctl.clear) begin
            plen_ff  <= '0;
            trunc_ff <= 1'b0;
         end else if (ctl.append) begin
            if (room) begin
               plen_ff <= plen_ff + CW'(1);
            end else begin
               trunc_ff <= 1'b1;
            end
         end
         if (restart) begin
            valid_ff <= '0;
         end else if (ctl.update && match) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (ctl.start) begin
            idx_ff <= plen_ff;
         end else if (ctl.update) begin
            idx_ff <= idx_ff - CW'(1);
         end
      end
   end

   // pattern store
   always_ff @(posedge clock) begin
      if (ctl.append && room) begin
         pat_mem[plen_ff[PW-1:0]] <= req_payload.symbol;
      end
      pat_rd_ff <= pat_mem[pat_addr];
   end

   // count row: write entry j, read entries j and j-1
   always_ff @(posedge clock) begin
      if (ctl.update && match) begin
         cnt_mem[idx_ff] <= sum;
      end
      a_data_ff <= cnt_mem[addr_a];
      b_data_ff <= cnt_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      a_valid_ff <= valid_ff[addr_a];
      b_valid_ff <= valid_ff[addr_b];
      a_zero_ff  <= addr_a == '0;
      b_zero_ff  <= addr_b == '0;
      if (ctl.start) begin
         sym_ff <= req_payload.symbol;
      end
      if (ctl.load_rsp) begin
         rsp_ff.count             <= a_val;
         rsp_ff.pattern_truncated <= trunc_ff;
      end
   end

`ifndef SYNTHESIS
   a_no_update_at_zero: assert property (@(posedge clock) disable iff (reset)
      ctl.update |-> idx_ff != '0)
      else $error("update at position zero");

   a_trunc_only_when_full: assert property (@(posedge clock) disable iff (reset)
      $rose(trunc_ff) |-> plen_ff == CW'(MAX_PATTERN))
      else $error("truncation flagged with room left");

   a_row_restarts: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |=> valid_ff == '0)
      else $error("row not restarted after result");
`endif

endmodule

// ===== design/distinct_subsequence_counter.sv =====
// ----------------------------------------------------------------------------
// distinct_subsequence_counter
// Counts the distinct subsequences of a streamed source string that equal a
// loaded pattern string, modulo 2^32.
// ----------------------------------------------------------------------------
// Load the pattern with append transactions (one symbol each, up to
// MAX_PATTERN; extra symbols are dropped and pattern_truncated stays set until
// a clear), then stream the source with source transactions and mark the
// final one with last. That transaction produces one result carrying the
// count; the count row restarts afterwards while the pattern is kept. Clear,
// append and unused-command transactions leave the sequencer idle. A source
// transaction walks the pattern positions, and a last one then adds a final
// read and an emit step, before the next transaction is accepted: the count
// row lives in a memory with one write and two read ports, and each pattern
// position is a read step followed by a compare-add-write step, walked from
// the top position down. A finished result waits in the output register while
// the next transactions are taken; if an earlier result still sits unread
// there, the emit step of a last source transaction holds until it is taken.
module distinct_subsequence_counter
   import dsc_pkg::*;
#(
   parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dsc_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dsc_rsp_type rsp_payload
);

   dsc_ctl_type ctl;
   dsc_sts_type sts;

   // sequencer: handshakes and position walk
   dsc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .ctl         (ctl),
      .sts         (sts)
   );

   // storage and arithmetic
   dsc_datapath #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl         (ctl),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/distinct_subsequence_counter_tb.sv =====
// ----------------------------------------------------------------------------
// distinct_subsequence_counter_tb
// Streams pattern and source transactions into the counter and checks each
// count and truncation flag against a behavioral count-row predictor. The
// run covers idle and stall phases, a long response hold-off and a random
// mix of short, dense (wrapping) and overfilled patterns.
// ----------------------------------------------------------------------------
module distinct_subsequence_counter_tb;
   import dsc_pkg::*;

   localparam int MAX_PATTERN  = DEF_MAX_PATTERN;
   localparam int CLK_PERIOD   = 10;
   localparam int HOLD_CYCLES  = 400;
   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int DRAIN_CYCLES = 2 * MAX_PATTERN + 16;
   localparam int PHASE_ITEMS  = 340;

   // Command code 3 has no meaning; the block must ignore it
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   dsc_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   dsc_rsp_type rsp_payload;

   // Predictor state: pattern symbols, the count row and the sticky flag
   logic [SYMBOL_W-1:0] pat_sym [MAX_PATTERN];
   int                  pat_len;
   logic [COUNT_W-1:0]  count_row [MAX_PATTERN+1];
   logic                trunc_flag;

   dsc_req_type pending_requests[$];
   dsc_rsp_type expected_counts[$];

   int pushed_items   = 0;
   int accepted_items = 0;
   int counted_items  = 0;
   int err_count      = 0;

   // Idle percentages of the current phase
   int snd_idle_pct  = 0;
   int rcv_stall_pct = 0;

   // Hold-off request: the stimulus bumps hold_seq, the receiver notices
   int hold_seq  = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // Alphabet of the job being built; size zero means any byte
   logic [SYMBOL_W-1:0] alphabet [4];
   int                  alphabet_size = 0;

   distinct_subsequence_counter #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   // -------------------------------------------------------------------------
   // Count predictor
   // -------------------------------------------------------------------------

   function automatic void restart_row();
      for (int j = 0; j <= MAX_PATTERN; j++) begin
         count_row[j] = '0;
      end
      count_row[0] = COUNT_W'(1);
   endfunction

   // Apply one accepted transaction; return 1 when it yields a result
   function automatic bit advance_count_row(input dsc_req_type t, output dsc_rsp_type r);
      r = '0;
      case (t.command)
         CMD_CLEAR: begin
            pat_len    = 0;
            trunc_flag = 1'b0;
            restart_row();
            return 1'b0;
         end
         CMD_APPEND: begin
            if (pat_len < MAX_PATTERN) begin
               pat_sym[pat_len] = t.symbol;
               pat_len++;
            end else begin
               trunc_flag = 1'b1;
            end
            restart_row();
            return 1'b0;
         end
         CMD_SOURCE: begin
            // Walk from the top position down so each entry sees the old j-1
            for (int j = pat_len; j >= 1; j--) begin
               if (pat_sym[j-1] == t.symbol) begin
                  count_row[j] = count_row[j] + count_row[j-1];
               end
            end
            if (!t.last) begin
               return 1'b0;
            end
            r.count             = count_row[pat_len];
            r.pattern_truncated = trunc_flag;
            restart_row();
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void report_error(input string what);
      err_count++;
      if (err_count <= 10) begin
         $display("ERROR @%0t: %s", $time, what);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Driver: offer queued transactions, predict on acceptance
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      dsc_rsp_type predicted;
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
         pat_len     = 0;
         trunc_flag  = 1'b0;
         restart_row();
      end else begin
         if (req_valid && req_ready) begin
            if (advance_count_row(req_payload, predicted)) begin
               expected_counts.push_back(predicted);
            end
            accepted_items++;
         end
         // Hold valid and payload until the transaction is taken
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= pending_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: check results, drive ready with stalls and the long hold-off
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      dsc_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               report_error($sformatf("unexpected result count=%08h trunc=%0b",
                                      rsp_payload.count, rsp_payload.pattern_truncated));
            end else begin
               want = expected_counts.pop_front();
               if (rsp_payload.count !== want.count) begin
                  report_error($sformatf("count expected %08h actual %08h",
                                         want.count, rsp_payload.count));
               end
               if (rsp_payload.pattern_truncated !== want.pattern_truncated) begin
                  report_error($sformatf("pattern_truncated expected %0b actual %0b",
                                         want.pattern_truncated,
                                         rsp_payload.pattern_truncated));
               end
            end
         end
         if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   task automatic push_item(input logic [1:0] cmd, input logic [SYMBOL_W-1:0] sym,
                            input logic lst);
      dsc_req_type t;
      t.command = cmd;
      t.symbol  = sym;
      t.last    = lst;
      pending_requests.push_back(t);
      pushed_items++;
      // Ignored commands do not count toward the stimulus size
      if (cmd != CMD_UNUSED) begin
         counted_items++;
      end
   endtask

   task automatic pick_alphabet(input int n);
      alphabet_size = n;
      for (int i = 0; i < 4; i++) begin
         alphabet[i] = SYMBOL_W'($urandom_range(255));
      end
   endtask

   function automatic logic [SYMBOL_W-1:0] pick_symbol();
      if (alphabet_size == 0) begin
         return SYMBOL_W'($urandom_range(255));
      end
      return alphabet[$urandom_range(alphabet_size - 1)];
   endfunction

   // Source string of n symbols, last on the final one, with stray unused codes
   task automatic push_source(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0) begin
            push_item(CMD_UNUSED, SYMBOL_W'($urandom_range(255)), 1'($urandom_range(1)));
         end
         push_item(CMD_SOURCE, pick_symbol(), i == n - 1);
      end
   endtask

   task automatic push_pattern(input int n);
      repeat (n) push_item(CMD_APPEND, pick_symbol(), 1'($urandom_range(1)));
   endtask

   task automatic push_random_job();
      int kind;
      int plen;
      kind = $urandom_range(99);
      if (kind < 10) begin
         // Noise: any command, any symbol, any last
         repeat ($urandom_range(1, 6)) begin
            push_item(2'($urandom_range(3)), SYMBOL_W'($urandom_range(255)),
                      1'($urandom_range(1)));
         end
      end else if (kind < 16) begin
         // Overfill the store so trailing symbols drop and the flag sets
         pick_alphabet($urandom_range(1, 4));
         push_item(CMD_CLEAR, SYMBOL_W'($urandom_range(255)), 1'($urandom_range(1)));
         push_pattern(MAX_PATTERN + $urandom_range(1, 3));
         push_source($urandom_range(1) ? $urandom_range(1, 6) : $urandom_range(64, 70));
      end else if (kind < 26) begin
         // Dense: tiny alphabet, long source, counts wrap past 2^32
         pick_alphabet($urandom_range(1, 2));
         push_item(CMD_CLEAR, SYMBOL_W'($urandom_range(255)), 1'($urandom_range(1)));
         push_pattern($urandom_range(6, 12));
         push_source($urandom_range(40, 80));
      end else begin
         // Ordinary job; without a clear the pattern grows on the old one
         pick_alphabet($urandom_range(0, 4));
         if ($urandom_range(9) < 7) begin
            push_item(CMD_CLEAR, SYMBOL_W'($urandom_range(255)), 1'($urandom_range(1)));
         end
         plen = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
         push_pattern(plen);
         repeat ($urandom_range(1, 3)) push_source($urandom_range(1, 12));
      end
   endtask

   // Pause the sender until every transaction is taken and every result is in
   task automatic wait_drained();
      while (accepted_items != pushed_items || expected_counts.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int target;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty pattern, ignored last and unused code, byte extremes,
      // pattern longer than source, pattern kept after a result, append
      // restarting the row mid-source, clear
      push_item(CMD_SOURCE, 8'h00, 1'b1);
      push_item(CMD_UNUSED, 8'hFF, 1'b1);
      push_item(CMD_APPEND, 8'hFF, 1'b1);
      push_item(CMD_APPEND, 8'h00, 1'b0);
      push_item(CMD_SOURCE, 8'hFF, 1'b0);
      push_item(CMD_SOURCE, 8'h00, 1'b1);
      push_item(CMD_SOURCE, 8'h00, 1'b1);
      push_item(CMD_APPEND, 8'h00, 1'b0);
      push_item(CMD_SOURCE, 8'hFF, 1'b0);
      push_item(CMD_SOURCE, 8'hFF, 1'b0);
      push_item(CMD_SOURCE, 8'h00, 1'b0);
      push_item(CMD_SOURCE, 8'h00, 1'b0);
      push_item(CMD_SOURCE, 8'h00, 1'b1);
      push_item(CMD_CLEAR,  8'hFF, 1'b1);
      push_item(CMD_SOURCE, 8'hAA, 1'b1);
      push_item(CMD_APPEND, 8'h55, 1'b0);
      push_item(CMD_APPEND, 8'hAA, 1'b0);
      push_item(CMD_SOURCE, 8'h55, 1'b0);
      push_item(CMD_APPEND, 8'h55, 1'b0);
      push_item(CMD_SOURCE, 8'h55, 1'b0);
      push_item(CMD_SOURCE, 8'hAA, 1'b0);
      push_item(CMD_SOURCE, 8'h55, 1'b1);
      push_item(CMD_CLEAR,  8'h00, 1'b0);
      wait_drained();

      // Random phases: no idling, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         snd_idle_pct  = (phase == 1) ? 48 : (phase == 3) ? 16 : 0;
         rcv_stall_pct = (phase == 2) ? 48 : (phase == 3) ? 16 : 0;
         if (phase == 0) begin
            // Hold off the receiver while short jobs keep coming, so the
            // result register fills and the input backs up
            hold_seq++;
            pick_alphabet(1);
            repeat (30) begin
               push_item(CMD_CLEAR, 8'h00, 1'b0);
               push_item(CMD_APPEND, pick_symbol(), 1'b0);
               push_source(1);
               push_source(2);
            end
            wait_drained();
         end
         target = counted_items + PHASE_ITEMS;
         while (counted_items < target) begin
            push_random_job();
         end
         wait_drained();
      end

      // Let any late, unexpected result show up before closing
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_counts.size() != 0) begin
         report_error($sformatf("%0d results never arrived", expected_counts.size()));
      end
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
